>>> rtl/core/packet_five_tuple_extractor_macros.svh
// Assertion macros shared by the RTL of the five-tuple extractor.
`ifndef PACKET_FIVE_TUPLE_EXTRACTOR_MACROS_SVH
`define PACKET_FIVE_TUPLE_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define PFTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfte assertion failed");
// Consequent holds on the clock edge after the antecedent.
`define PFTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfte assertion failed");
`else
`define PFTE_ASSERT(lbl, clk, rst_n, prop)
`define PFTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/pfte_pkg.sv
// Types and constants shared by the five-tuple extractor modules.
package pfte_pkg;

  localparam logic [4:0]  EthHeaderLen   = 5'd14;
  localparam logic [4:0]  VlanHeaderLen  = 5'd18;
  localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
  localparam logic [15:0] EtherTypeVlan  = 16'h8100;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [7:0]  ProtoUdp       = 8'd17;
  localparam logic [3:0]  IpVersion4     = 4'd4;
  localparam logic [16:0] ChecksumGood   = 17'h0FFFF;
  localparam logic [15:0] OffsetMax      = 16'hFFFF;

  localparam logic [1:0]  CfgRawIpLink       = 2'd0;
  localparam logic [1:0]  CfgChecksumEnable  = 2'd1;
  localparam logic [1:0]  CfgMaxCaptureLen   = 2'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        packet_valid;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
  } result_t;

  typedef struct packed {
    logic        raw_ip_link;
    logic        checksum_check_enable;
    logic [15:0] max_capture_length;
  } cfg_t;

  // Everything the back end needs to judge one finished packet.
  typedef struct packed {
    logic [15:0] pkt_len;
    logic [4:0]  link_hdr_len;
    logic [15:0] eth_type;
    logic [3:0]  header_words;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
    logic [31:0] ports;
    logic [3:0]  tcp_offset_words;
    logic [16:0] checksum_sum;
  } summary_t;

endpackage

>>> rtl/core/pfte_front.sv
// Byte parser: captures header fields as bytes pass and emits a summary at packet end.
`include "packet_five_tuple_extractor_macros.svh"

module pfte_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfte_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  pfte_pkg::in_item_t in_item_i,
  output logic               summary_push_o,
  output pfte_pkg::summary_t summary_o
);
  import pfte_pkg::*;

  logic [15:0] offset_q, offset_d;
  logic [4:0]  lhl_q, lhl_d, lhl_cur;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  hw_q, hw_d;
  logic [3:0]  ver_q, ver_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [31:0] ports_q, ports_d;
  logic [3:0]  tcp_q, tcp_d;
  logic [16:0] sum_q, sum_d;

  logic [15:0] idx, rel, l4, pkt_len;
  logic [15:0] addend;
  logic [17:0] sum_raw;
  logic [1:0]  pos;
  logic [7:0]  b;
  logic        take;

  always_comb begin
    idx      = offset_q;
    b        = in_item_i.data_byte;
    lhl_cur  = (idx == '0) ? (cfg_i.raw_ip_link ? 5'd0 : EthHeaderLen) : lhl_q;
    take     = idx < cfg_i.max_capture_length;
    lhl_d    = lhl_cur;
    eth_d    = eth_q;
    hw_d     = hw_q;
    ver_d    = ver_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    ports_d  = ports_q;
    tcp_d    = tcp_q;
    sum_d    = sum_q;
    rel      = '0;
    l4       = '0;
    pos      = '0;
    addend   = '0;
    sum_raw  = '0;
    if (take) begin
      if (lhl_cur != '0) begin
        if (idx == 16'd12) eth_d[15:8] = b;
        if (idx == 16'd13) begin
          eth_d[7:0] = b;
          if (eth_d == EtherTypeVlan) lhl_d = VlanHeaderLen;
        end
      end
      if (idx >= {11'd0, lhl_d}) begin
        rel = idx - {11'd0, lhl_d};
        if (rel == '0) begin
          ver_d = b[7:4];
          hw_d  = b[3:0];
        end
        if (rel == 16'd9) proto_d = b;
        if (rel >= 16'd12 && rel < 16'd16) src_d = {src_q[23:0], b};
        if (rel >= 16'd16 && rel < 16'd20) dst_d = {dst_q[23:0], b};
        // The layer-4 header position follows the length just captured.
        l4 = {10'd0, hw_d, 2'b00};
        if (rel >= l4 && rel < l4 + 16'd4) begin
          pos = 2'(rel - l4);
          unique case (pos)
            2'd0: ports_d[31:24] = b;
            2'd1: ports_d[23:16] = b;
            2'd2: ports_d[15:8]  = b;
            2'd3: ports_d[7:0]   = b;
          endcase
        end
        if (rel == l4 + 16'd12) tcp_d = b[7:4];
        if (rel < l4) begin
          addend  = rel[0] ? {8'd0, b} : {b, 8'd0};
          sum_raw = 18'(sum_q) + 18'(addend);
          sum_d   = 17'(sum_raw[15:0]) + 17'(sum_raw[17:16]);
        end
      end
    end
    offset_d = (idx != OffsetMax) ? idx + 16'd1 : idx;
    pkt_len  = (offset_d < cfg_i.max_capture_length) ? offset_d : cfg_i.max_capture_length;
  end

  always_comb begin
    summary_push_o             = accept_i && in_item_i.last_byte;
    summary_o.pkt_len          = pkt_len;
    summary_o.link_hdr_len     = lhl_d;
    summary_o.eth_type         = eth_d;
    summary_o.header_words     = hw_d;
    summary_o.ip_version       = ver_d;
    summary_o.protocol         = proto_d;
    summary_o.source           = src_d;
    summary_o.destination      = dst_d;
    summary_o.ports            = ports_d;
    summary_o.tcp_offset_words = tcp_d;
    summary_o.checksum_sum     = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      lhl_q    <= '0;
      eth_q    <= '0;
      hw_q     <= '0;
      ver_q    <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      ports_q  <= '0;
      tcp_q    <= '0;
      sum_q    <= '0;
    end else if (accept_i) begin
      if (in_item_i.last_byte) begin
        offset_q <= '0;
        lhl_q    <= '0;
        eth_q    <= '0;
        hw_q     <= '0;
        ver_q    <= '0;
        proto_q  <= '0;
        src_q    <= '0;
        dst_q    <= '0;
        ports_q  <= '0;
        tcp_q    <= '0;
        sum_q    <= '0;
      end else begin
        offset_q <= offset_d;
        lhl_q    <= lhl_d;
        eth_q    <= eth_d;
        hw_q     <= hw_d;
        ver_q    <= ver_d;
        proto_q  <= proto_d;
        src_q    <= src_d;
        dst_q    <= dst_d;
        ports_q  <= ports_d;
        tcp_q    <= tcp_d;
        sum_q    <= sum_d;
      end
    end
  end

  `PFTE_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, accept_i && in_item_i.last_byte,
                    offset_q == '0 && lhl_q == '0 && sum_q == '0)
  `PFTE_ASSERT_NEXT(a_offset_counts, clk_i, rst_ni,
                    accept_i && !in_item_i.last_byte && offset_q != OffsetMax,
                    offset_q == 16'($past(offset_q) + 16'd1))
  `PFTE_ASSERT(a_link_len_legal, clk_i, rst_ni,
               lhl_q == 5'd0 || lhl_q == EthHeaderLen || lhl_q == VlanHeaderLen)
  `PFTE_ASSERT(a_sum_folded, clk_i, rst_ni, sum_q <= 17'h10000)

endmodule

>>> rtl/core/pfte_queue.sv
// Short queue of packet summaries between the parser and the result stage.
module pfte_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pfte_pkg::summary_t push_data_i,
  input  logic               pop_i,
  output pfte_pkg::summary_t head_o,
  output logic               not_empty_o,
  output logic               full_o
);
  import pfte_pkg::*;

  summary_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   do_push, do_pop;

  always_comb begin
    do_push  = push_i && (count_q != QueueCntW'(QueueDepth));
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = count_q != '0;
  assign full_o      = count_q == QueueCntW'(QueueDepth);

endmodule

>>> rtl/core/pfte_back.sv
// Result stage: judges a packet summary and holds the finished result for the reader.
module pfte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfte_pkg::cfg_t     cfg_i,
  input  pfte_pkg::summary_t summary_i,
  input  logic               summary_valid_i,
  output logic               summary_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pfte_pkg::result_t  result_o
);
  import pfte_pkg::*;

  logic               out_valid_q, out_valid_d;
  result_t            result_q, result_d;
  logic               load, taken, link_bad, ok;
  logic signed [17:0] len, hl4, tcp_need, short_need;

  always_comb begin
    link_bad   = (summary_i.link_hdr_len != '0) && (summary_i.eth_type != EtherTypeIpv4)
                 && (summary_i.eth_type != EtherTypeVlan);
    len        = $signed({2'b00, summary_i.pkt_len}) - $signed({13'd0, summary_i.link_hdr_len});
    hl4        = $signed({12'd0, summary_i.header_words, 2'b00});
    tcp_need   = hl4 + $signed({12'd0, summary_i.tcp_offset_words, 2'b00});
    short_need = hl4 + 18'sd8;
    ok = !link_bad && !(len < hl4) && (summary_i.ip_version == IpVersion4)
         && !(cfg_i.checksum_check_enable && summary_i.checksum_sum != ChecksumGood);
    // Other protocols carry no layer-4 length check.
    if (summary_i.protocol == ProtoTcp) begin
      if (len < tcp_need) ok = 1'b0;
    end else if (summary_i.protocol == ProtoUdp || summary_i.protocol == ProtoIcmp) begin
      if (len < short_need) ok = 1'b0;
    end
    result_d = '0;
    if (ok) begin
      result_d.packet_valid        = 1'b1;
      result_d.source_address      = summary_i.source;
      result_d.destination_address = summary_i.destination;
      result_d.protocol_number     = summary_i.protocol;
      if (summary_i.protocol == ProtoTcp || summary_i.protocol == ProtoUdp) begin
        result_d.source_port      = summary_i.ports[31:16];
        result_d.destination_port = summary_i.ports[15:0];
      end
    end
  end

  always_comb begin
    taken       = pop_i && out_valid_q;
    load        = summary_valid_i && (!out_valid_q || taken);
    out_valid_d = load ? 1'b1 : (taken ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) result_q <= result_d;
  end

  assign summary_pop_o = load;
  assign empty_o       = !out_valid_q;
  assign result_o      = result_q;

endmodule

>>> rtl/core/packet_five_tuple_extractor.sv
// Top level of the IPv4 five-tuple extractor: configuration registers and stage wiring.

// The extractor takes one captured packet byte per request, in wire order, and
// after the byte flagged last_byte it delivers one result holding a validity
// flag and the IPv4 source and destination addresses, the TCP or UDP ports and
// the protocol number; an invalid packet gives a result that is all zero. A
// byte is taken in every clock cycle while full is low, and packets may follow
// one another with no gap. The front parser registers header fields as their
// bytes pass and, on the last byte, writes a packet summary into a two-entry
// queue; the result stage checks that summary and loads its output register,
// so a result passes through the queue and the output register before it
// shows on the result ports. Full rises only while two summaries wait behind
// an unread result, which stalls all input bytes until the reader pops.
// Configuration writes are always taken (ready is tied high) and should only
// be made while no packet is in flight; raw_ip_link is sampled at the first
// byte of each packet.
`include "packet_five_tuple_extractor_macros.svh"

module packet_five_tuple_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pfte_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output pfte_pkg::result_t  result_o,
  input  logic               valid,
  output logic               ready,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import pfte_pkg::*;

  cfg_t     cfg_q, cfg_d;
  summary_t front_summary, queue_head;
  logic     accept, front_push, queue_pop, queue_not_empty, queue_full;

  // Register writes; an index beyond the list is accepted and dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (valid && ready) begin
      unique case (cfg_index_i)
        CfgRawIpLink:      cfg_d.raw_ip_link           = cfg_data_i[0];
        CfgChecksumEnable: cfg_d.checksum_check_enable = cfg_data_i[0];
        CfgMaxCaptureLen:  cfg_d.max_capture_length    = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_ip_link           <= 1'b0;
      cfg_q.checksum_check_enable <= 1'b1;
      cfg_q.max_capture_length    <= 16'hFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign ready  = 1'b1;
  assign full   = queue_full;
  assign accept = push && !queue_full;

  pfte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .in_item_i      (in_item_i),
    .summary_push_o (front_push),
    .summary_o      (front_summary)
  );

  pfte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_data_i (front_summary),
    .pop_i       (queue_pop),
    .head_o      (queue_head),
    .not_empty_o (queue_not_empty),
    .full_o      (queue_full)
  );

  pfte_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .summary_i       (queue_head),
    .summary_valid_i (queue_not_empty),
    .summary_pop_o   (queue_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .result_o        (result_o)
  );

  // A queued summary must reach the output register as soon as it is free.
  `PFTE_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, queue_not_empty, !empty)
  // The queue only fills while a result is waiting to be read.
  `PFTE_ASSERT(a_full_needs_result, clk_i, rst_ni, !queue_full || !empty)
  // A last byte that is taken is always registered as a queued summary or a waiting result.
  `PFTE_ASSERT_NEXT(a_last_queued, clk_i, rst_ni, accept && in_item_i.last_byte, queue_not_empty || !empty)

endmodule
